// ----- sv/kce_pkg.sv -----
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types, key codes and widths of the keypad calculator evaluator.
// ----------------------------------------------------------------------------
package kce_pkg;

    // Defaults of the top level parameters
    localparam int MAX_KEYS_DEF      = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int KEY_W    = 8;
    localparam int OPND_W   = 16;
    localparam int INT_W    = 47;
    localparam int HUND_W   = 7;
    localparam int STATUS_W = 2;
    localparam int MAG_MAX_W = 63;

    // Key codes (ASCII)
    localparam logic [KEY_W-1:0] KEY_CLEAR = 8'h23;  // '#'
    localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;  // '+'
    localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;  // '-'
    localparam logic [KEY_W-1:0] KEY_TIMES = 8'h2A;  // '*'
    localparam logic [KEY_W-1:0] KEY_SLASH = 8'h2F;  // '/'
    localparam logic [KEY_W-1:0] KEY_EQUAL = 8'h3D;  // '='
    localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;  // '0'
    localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;  // '9'

    // Fraction scaling for the hundredths digits
    localparam logic [HUND_W-1:0] HUNDRED = 7'd100;
    localparam logic [HUND_W-1:0] MAX_HUNDREDTHS = 7'd99;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    // Request to the serial multiply / divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_alu_req;

    // Response of the serial multiply / divide unit
    typedef struct packed {
        logic done;
        logic ovf;
    } t_alu_rsp;

    // Magnitude width of the accumulator for a given fraction width
    function automatic int mag_width(input int frac_bits);
        mag_width = (INT_W + frac_bits >= MAG_MAX_W) ? MAG_MAX_W : INT_W + frac_bits;
    endfunction

endpackage

// ----- sv/kce_serial_alu.sv -----
// ----------------------------------------------------------------------------
// kce_serial_alu
// Bit-serial unit: shift-and-add multiply of the accumulator magnitude by the
// 16-bit operand (one operand bit a cycle) and restoring divide of the
// magnitude by the operand (one quotient bit a cycle).
// ----------------------------------------------------------------------------
module kce_serial_alu #(
    parameter int MAG_W = kce_pkg::mag_width(kce_pkg::FRACTION_BITS_DEF)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kce_pkg::t_alu_req         i_req,
    input  logic [MAG_W-1:0]          i_acc_mag,
    input  logic [kce_pkg::OPND_W-1:0] i_opnd,
    output kce_pkg::t_alu_rsp         o_rsp,
    output logic [MAG_W-1:0]          o_mag
);

    localparam int OW = kce_pkg::OPND_W;
    localparam int PW = MAG_W + OW;
    localparam int CW = $clog2(MAG_W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_is_div, n_is_div;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_work, n_work;
    logic [MAG_W-1:0] r_base, n_base;
    logic [OW-1:0] r_opnd, n_opnd;
    logic [OW-1:0] r_rem, n_rem;

    logic [CW-1:0] last_cnt;
    logic [PW-1:0] mul_next;
    logic [OW:0]   rem_sh;
    logic [OW:0]   rem_sub;
    logic          rem_ge;

    // One multiply step: shift the partial product, add the base on a set bit
    assign mul_next = {r_work[PW-2:0], 1'b0} + (r_opnd[OW-1] ? PW'(r_base) : '0);

    // One divide step: bring down the next dividend bit, subtract on fit
    assign rem_sh  = {r_rem, r_work[MAG_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_opnd};
    assign rem_ge  = (rem_sh >= {1'b0, r_opnd});

    assign last_cnt = r_is_div ? CW'(MAG_W - 1) : CW'(OW - 1);

    // Sequence the iterations
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_is_div = r_is_div;
        n_cnt    = r_cnt;
        n_work   = r_work;
        n_base   = r_base;
        n_opnd   = r_opnd;
        n_rem    = r_rem;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_is_div = i_req.is_div;
            n_cnt    = '0;
            n_base   = i_acc_mag;
            n_opnd   = i_opnd;
            n_rem    = '0;
            n_work   = i_req.is_div ? PW'(i_acc_mag) : '0;
        end else if (r_busy) begin
            if (r_is_div) begin
                n_work = PW'({r_work[MAG_W-2:0], rem_ge});
                n_rem  = rem_ge ? rem_sub[OW-1:0] : rem_sh[OW-1:0];
            end else begin
                n_work = mul_next;
                n_opnd = {r_opnd[OW-2:0], 1'b0};
            end
            if (r_cnt == last_cnt) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_is_div <= n_is_div;
        r_cnt    <= n_cnt;
        r_work   <= n_work;
        r_base   <= n_base;
        r_opnd   <= n_opnd;
        r_rem    <= n_rem;
    end

    // Product bits above the magnitude mean overflow; a quotient never does
    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = !r_is_div && (|r_work[PW-1:MAG_W]);
    assign o_mag      = r_work[MAG_W-1:0];

endmodule

// ----- sv/kce_result_stage.sv -----
// ----------------------------------------------------------------------------
// kce_result_stage
// Output register: splits the accumulator into integer part and truncated
// hundredths and holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
module kce_result_stage #(
    parameter int FRACTION_BITS = kce_pkg::FRACTION_BITS_DEF,
    parameter int MAG_W         = kce_pkg::mag_width(kce_pkg::FRACTION_BITS_DEF)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_acc_neg,
    input  logic [MAG_W-1:0]              i_acc_mag,
    input  kce_pkg::t_status              i_err,
    input  logic                          i_stall,
    output logic                          o_free,
    output logic                          o_valid,
    output logic                          o_is_negative,
    output logic [kce_pkg::INT_W-1:0]     o_integer_part,
    output logic [kce_pkg::HUND_W-1:0]    o_hundredths,
    output logic [kce_pkg::STATUS_W-1:0]  o_status
);

    localparam int HW = kce_pkg::HUND_W;
    localparam int FW = FRACTION_BITS + HW;

    logic                         r_valid, n_valid;
    logic                         r_neg;
    logic [kce_pkg::INT_W-1:0]    r_int;
    logic [HW-1:0]                r_hund;
    logic [kce_pkg::STATUS_W-1:0] r_status;

    logic [FW-1:0] frac_scaled;
    logic [HW-1:0] hund;

    // Scale the fraction by one hundred and keep the integer digits
    assign frac_scaled = FW'(i_acc_mag[FRACTION_BITS-1:0]) * FW'(kce_pkg::HUNDRED);
    assign hund        = i_acc_neg ? '0 : frac_scaled[FW-1:FRACTION_BITS];

    assign o_free = !r_valid || !i_stall;

    // Hold the word until taken, load a new one when free
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_neg    <= i_acc_neg;
            r_int    <= kce_pkg::INT_W'(i_acc_mag[MAG_W-1:FRACTION_BITS]);
            r_hund   <= hund;
            r_status <= i_err;
        end
    end

    assign o_valid        = r_valid;
    assign o_is_negative  = r_neg;
    assign o_integer_part = r_int;
    assign o_hundredths   = r_hund;
    assign o_status       = r_status;

endmodule

// ----- sv/keypad_calculator_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// keypad_calculator_evaluator_core
// Left-to-right four-function calculator fed with ASCII key codes.
// ----------------------------------------------------------------------------
// Each key word is taken when the core is idle. A digit, an ignored code, a
// clear, an add, a subtract, the first operator of an expression and a divide
// by zero are handled in the idle state. A multiply, and a divide by a nonzero
// operand, run through the bit-serial unit, one operand or quotient bit a
// cycle. A key that ends an expression ('=' or the MAX_KEYS-th key) passes
// through the emit state to move the result into the output register, and
// waits there while an earlier result word is still stalled.
// The accumulator is sign and magnitude, Q(MAG_W - FRACTION_BITS).FRACTION_BITS,
// saturating at all ones in the magnitude.
// ----------------------------------------------------------------------------
module keypad_calculator_evaluator_core #(
    parameter int MAX_KEYS      = kce_pkg::MAX_KEYS_DEF,
    parameter int FRACTION_BITS = kce_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [kce_pkg::KEY_W-1:0]     i_key_code,
    output logic                          o_stall,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_is_negative,
    output logic [kce_pkg::INT_W-1:0]     o_integer_part,
    output logic [kce_pkg::HUND_W-1:0]    o_hundredths,
    output logic [kce_pkg::STATUS_W-1:0]  o_status
);

    localparam int MAG_W = kce_pkg::mag_width(FRACTION_BITS);
    localparam int OW    = kce_pkg::OPND_W;
    localparam int KW    = $clog2(MAX_KEYS + 1);

    kce_pkg::t_state  r_state, n_state;
    logic             r_acc_neg, n_acc_neg;
    logic [MAG_W-1:0] r_acc_mag, n_acc_mag;
    logic [OW-1:0]    r_operand, n_operand;
    kce_pkg::t_op     r_pending, n_pending;
    logic             r_first, n_first;
    logic [KW-1:0]    r_keys, n_keys;
    kce_pkg::t_status r_err, n_err;
    logic             r_finish, n_finish;

    kce_pkg::t_alu_req alu_req;
    kce_pkg::t_alu_rsp alu_rsp;
    logic [MAG_W-1:0]  alu_mag;

    logic             key_acc;
    logic             is_digit, is_oper, is_eq;
    logic             clear_all;
    logic             out_load, out_free;
    logic [MAG_W-1:0] scaled;
    logic [MAG_W:0]   sum;
    logic [MAG_W-1:0] diff_a, diff_b;
    logic             add_neg, acc_ge;
    kce_pkg::t_status err_ovf;
    kce_pkg::t_status err_div0;

    assign key_acc  = i_valid && !o_stall;
    assign is_digit = (i_key_code >= kce_pkg::KEY_ZERO) && (i_key_code <= kce_pkg::KEY_NINE);
    assign is_eq    = (i_key_code == kce_pkg::KEY_EQUAL);
    assign is_oper  = (i_key_code == kce_pkg::KEY_PLUS) || (i_key_code == kce_pkg::KEY_MINUS) ||
                      (i_key_code == kce_pkg::KEY_TIMES) || (i_key_code == kce_pkg::KEY_SLASH) ||
                      is_eq;

    // Operand in accumulator scale, and the signed add or subtract of it
    assign scaled  = MAG_W'({r_operand, {FRACTION_BITS{1'b0}}});
    assign add_neg = (r_pending == kce_pkg::OP_SUB);
    assign sum     = {1'b0, r_acc_mag} + {1'b0, scaled};
    assign acc_ge  = (r_acc_mag >= scaled);
    assign diff_a  = r_acc_mag - scaled;
    assign diff_b  = scaled - r_acc_mag;

    // Keep the first error of an expression
    assign err_ovf  = (r_err == kce_pkg::ST_OK) ? kce_pkg::ST_OVF  : r_err;
    assign err_div0 = (r_err == kce_pkg::ST_OK) ? kce_pkg::ST_DIV0 : r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kce_pkg::S_IDLE;
            r_acc_neg <= 1'b0;
            r_acc_mag <= '0;
            r_operand <= '0;
            r_pending <= kce_pkg::OP_ADD;
            r_first   <= 1'b1;
            r_keys    <= '0;
            r_err     <= kce_pkg::ST_OK;
            r_finish  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc_neg <= n_acc_neg;
            r_acc_mag <= n_acc_mag;
            r_operand <= n_operand;
            r_pending <= n_pending;
            r_first   <= n_first;
            r_keys    <= n_keys;
            r_err     <= n_err;
            r_finish  <= n_finish;
        end
    end

    // Decode keys, apply operators and sequence the result
    always_comb begin
        n_state        = r_state;
        n_acc_neg      = r_acc_neg;
        n_acc_mag      = r_acc_mag;
        n_operand      = r_operand;
        n_pending      = r_pending;
        n_first        = r_first;
        n_keys         = r_keys;
        n_err          = r_err;
        n_finish       = r_finish;
        alu_req.start  = 1'b0;
        alu_req.is_div = (r_pending == kce_pkg::OP_DIV);
        out_load       = 1'b0;
        clear_all      = 1'b0;

        case (r_state)
            kce_pkg::S_IDLE: begin
                if (key_acc) begin
                    if (i_key_code == kce_pkg::KEY_CLEAR) begin
                        clear_all = 1'b1;
                    end else begin
                        n_keys   = r_keys + 1'b1;
                        n_finish = (n_keys == KW'(MAX_KEYS));
                        if (is_digit) begin
                            n_operand = OW'(r_operand * OW'(10) + OW'(i_key_code[3:0]));
                        end else if (is_oper) begin
                            n_operand = '0;
                            n_finish  = n_finish || is_eq;
                            if (i_key_code == kce_pkg::KEY_PLUS) begin
                                n_pending = kce_pkg::OP_ADD;
                            end else if (i_key_code == kce_pkg::KEY_MINUS) begin
                                n_pending = kce_pkg::OP_SUB;
                            end else if (i_key_code == kce_pkg::KEY_TIMES) begin
                                n_pending = kce_pkg::OP_MUL;
                            end else if (i_key_code == kce_pkg::KEY_SLASH) begin
                                n_pending = kce_pkg::OP_DIV;
                            end
                            if (r_first) begin
                                // Load the first operand
                                n_acc_mag = scaled;
                                n_acc_neg = 1'b0;
                                n_first   = 1'b0;
                            end else begin
                                case (r_pending)
                                    kce_pkg::OP_ADD, kce_pkg::OP_SUB: begin
                                        if (add_neg == r_acc_neg) begin
                                            if (sum[MAG_W]) begin
                                                n_acc_mag = '1;
                                                n_acc_neg = add_neg;
                                                n_err     = err_ovf;
                                            end else begin
                                                n_acc_mag = sum[MAG_W-1:0];
                                                n_acc_neg = add_neg && (|sum[MAG_W-1:0]);
                                            end
                                        end else if (acc_ge) begin
                                            n_acc_mag = diff_a;
                                            n_acc_neg = r_acc_neg && (|diff_a);
                                        end else begin
                                            n_acc_mag = diff_b;
                                            n_acc_neg = add_neg;
                                        end
                                    end
                                    kce_pkg::OP_MUL: begin
                                        alu_req.start = 1'b1;
                                        n_state       = kce_pkg::S_CALC;
                                    end
                                    default: begin
                                        if (r_operand == '0) begin
                                            if (r_acc_mag != '0) begin
                                                n_acc_mag = '1;
                                            end
                                            n_err = err_div0;
                                        end else begin
                                            alu_req.start = 1'b1;
                                            n_state       = kce_pkg::S_CALC;
                                        end
                                    end
                                endcase
                            end
                        end
                        if (!alu_req.start && n_finish) begin
                            n_state = kce_pkg::S_EMIT;
                        end
                    end
                end
            end
            kce_pkg::S_CALC: begin
                if (alu_rsp.done) begin
                    if (alu_rsp.ovf) begin
                        n_acc_mag = '1;
                        n_err     = err_ovf;
                    end else begin
                        n_acc_mag = alu_mag;
                        n_acc_neg = r_acc_neg && (|alu_mag);
                    end
                    n_state = r_finish ? kce_pkg::S_EMIT : kce_pkg::S_IDLE;
                end
            end
            kce_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    clear_all = 1'b1;
                    n_state   = kce_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kce_pkg::S_IDLE;
            end
        endcase

        // Drop the whole expression
        if (clear_all) begin
            n_acc_neg = 1'b0;
            n_acc_mag = '0;
            n_operand = '0;
            n_pending = kce_pkg::OP_ADD;
            n_first   = 1'b1;
            n_keys    = '0;
            n_err     = kce_pkg::ST_OK;
            n_finish  = 1'b0;
        end
    end

    assign o_stall = (r_state != kce_pkg::S_IDLE);

    kce_serial_alu #(
        .MAG_W (MAG_W)
    ) u_alu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (alu_req),
        .i_acc_mag (r_acc_mag),
        .i_opnd    (r_operand),
        .o_rsp     (alu_rsp),
        .o_mag     (alu_mag)
    );

    kce_result_stage #(
        .FRACTION_BITS (FRACTION_BITS),
        .MAG_W         (MAG_W)
    ) u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (out_load),
        .i_acc_neg      (r_acc_neg),
        .i_acc_mag      (r_acc_mag),
        .i_err          (r_err),
        .i_stall        (i_stall),
        .o_free         (out_free),
        .o_valid        (o_valid),
        .o_is_negative  (o_is_negative),
        .o_integer_part (o_integer_part),
        .o_hundredths   (o_hundredths),
        .o_status       (o_status)
    );

endmodule

// ----- sv/kce_checker.sv -----
// ----------------------------------------------------------------------------
// kce_checker
// Port-level checks of the calculator core, bound to the top level.
// ----------------------------------------------------------------------------
module kce_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic [kce_pkg::KEY_W-1:0]     i_key_code,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_is_negative,
    input logic [kce_pkg::INT_W-1:0]     o_integer_part,
    input logic [kce_pkg::HUND_W-1:0]    o_hundredths,
    input logic [kce_pkg::STATUS_W-1:0]  o_status
);

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_integer_part) &&
        $stable(o_hundredths) && $stable(o_status) && $stable(o_is_negative))
        else $error("stalled result word changed");

    // A clear key never produces a result word
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_key_code == kce_pkg::KEY_CLEAR) |=> !$rose(o_valid))
        else $error("clear key produced a result");

    // Hundredths stay two decimal digits
    a_hund: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hundredths <= kce_pkg::MAX_HUNDREDTHS)
        else $error("hundredths out of range");

    // Negative results carry no hundredths
    a_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_negative |-> o_hundredths == '0)
        else $error("negative result with hundredths");

    // Status is ok, divide by zero or overflow
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == kce_pkg::ST_OK) || (o_status == kce_pkg::ST_DIV0) ||
        (o_status == kce_pkg::ST_OVF))
        else $error("undefined status code");

endmodule

bind keypad_calculator_evaluator_core kce_checker u_kce_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the keypad calculator evaluator against a left-to-right predictor.
// Key words go in through a bursty sender. Each expected result is worked out
// when its key word is taken, and is queued. Every result word that leaves
// the core is checked field by field against the oldest queued one. Directed
// expressions cover each operator, sign and hundredths, divide by zero with
// later saturation, clear and ignored codes, and the key limit. Random
// expressions run before and after a long output hold-off backing up the core.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_KEYS     = kce_pkg::MAX_KEYS_DEF;
    localparam int FRAC_BITS    = kce_pkg::FRACTION_BITS_DEF;
    localparam int MAG_W        = kce_pkg::mag_width(FRAC_BITS);
    localparam logic [63:0] MAG_LIMIT = (64'd1 << MAG_W) - 64'd1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_KEYS  = 160;

    // Ignored codes at the two ends of the key range
    localparam logic [kce_pkg::KEY_W-1:0] KEY_LOWEST  = 8'h00;
    localparam logic [kce_pkg::KEY_W-1:0] KEY_HIGHEST = 8'hFF;

    typedef struct {
        logic                         neg;
        logic [kce_pkg::INT_W-1:0]    int_part;
        logic [kce_pkg::HUND_W-1:0]   hund;
        logic [kce_pkg::STATUS_W-1:0] status;
    } t_calc_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic [kce_pkg::KEY_W-1:0]     i_key_code;
    logic                          o_stall;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic                          o_is_negative;
    logic [kce_pkg::INT_W-1:0]     o_integer_part;
    logic [kce_pkg::HUND_W-1:0]    o_hundredths;
    logic [kce_pkg::STATUS_W-1:0]  o_status;

    // Predictor state
    logic                          acc_neg;
    logic [63:0]                   acc_mag;
    logic [kce_pkg::OPND_W-1:0]    operand;
    kce_pkg::t_op                  pending_op;
    logic                          first_pending;
    int                            key_count;
    kce_pkg::t_status              first_error;

    t_calc_result         expected_results[$];
    t_calc_result         oldest_result;

    int keys_sent      = 0;
    int results_seen   = 0;
    int neg_results    = 0;
    int div0_results   = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    bit no_gaps        = 1'b0;
    int hold_request   = 0;
    int hold_left      = 0;
    int pattern_cycle  = 0;

    keypad_calculator_evaluator_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_key_code     (i_key_code),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_negative  (o_is_negative),
        .o_integer_part (o_integer_part),
        .o_hundredths   (o_hundredths),
        .o_status       (o_status)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_calc();
        acc_neg       = 1'b0;
        acc_mag       = '0;
        operand       = '0;
        pending_op    = kce_pkg::OP_ADD;
        first_pending = 1'b1;
        key_count     = 0;
        first_error   = kce_pkg::ST_OK;
    endfunction

    // Keep only the first error of an expression
    function automatic void record_error(input kce_pkg::t_status code);
        if (first_error == kce_pkg::ST_OK) begin
            first_error = code;
        end
    endfunction

    // Saturate the magnitude and never hold a negative zero
    function automatic void load_acc(input logic neg, input logic [63:0] mag);
        if (mag > MAG_LIMIT) begin
            mag = MAG_LIMIT;
            record_error(kce_pkg::ST_OVF);
        end
        acc_mag = mag;
        acc_neg = (mag != 0) ? neg : 1'b0;
    endfunction

    function automatic void add_to_acc(input logic neg, input logic [63:0] mag);
        if (neg == acc_neg) begin
            load_acc(neg, acc_mag + mag);
        end else if (acc_mag >= mag) begin
            load_acc(acc_neg, acc_mag - mag);
        end else begin
            load_acc(neg, mag - acc_mag);
        end
    endfunction

    function automatic void apply_pending();
        logic [63:0] opnd;
        logic [63:0] scaled;
        opnd   = 64'(operand);
        scaled = opnd << FRAC_BITS;
        if (first_pending) begin
            load_acc(1'b0, scaled);
            first_pending = 1'b0;
            return;
        end
        case (pending_op)
            kce_pkg::OP_ADD: add_to_acc(1'b0, scaled);
            kce_pkg::OP_SUB: add_to_acc(1'b1, scaled);
            kce_pkg::OP_MUL: begin
                if (opnd != 0 && acc_mag > MAG_LIMIT / opnd) begin
                    load_acc(acc_neg, MAG_LIMIT);
                    record_error(kce_pkg::ST_OVF);
                end else begin
                    load_acc(acc_neg, acc_mag * opnd);
                end
            end
            default: begin
                if (opnd == 0) begin
                    if (acc_mag != 0) begin
                        load_acc(acc_neg, MAG_LIMIT);
                    end
                    record_error(kce_pkg::ST_DIV0);
                end else begin
                    load_acc(acc_neg, acc_mag / opnd);
                end
            end
        endcase
    endfunction

    // Advance the calculator by one key; return 1 when it gives a result
    function automatic bit evaluate_key(input logic [kce_pkg::KEY_W-1:0] key,
                                        output t_calc_result res);
        logic        finish;
        logic [63:0] frac;
        finish = 1'b0;
        res    = '{default: '0};
        if (key == kce_pkg::KEY_CLEAR) begin
            clear_calc();
            return 1'b0;
        end
        key_count = (key_count + 1) & 31;
        if (key >= kce_pkg::KEY_ZERO && key <= kce_pkg::KEY_NINE) begin
            operand = kce_pkg::OPND_W'(32'(operand) * 10 + 32'(key - kce_pkg::KEY_ZERO));
        end else if (key == kce_pkg::KEY_PLUS || key == kce_pkg::KEY_MINUS ||
                     key == kce_pkg::KEY_TIMES || key == kce_pkg::KEY_SLASH ||
                     key == kce_pkg::KEY_EQUAL) begin
            apply_pending();
            operand = '0;
            case (key)
                kce_pkg::KEY_PLUS:  pending_op = kce_pkg::OP_ADD;
                kce_pkg::KEY_MINUS: pending_op = kce_pkg::OP_SUB;
                kce_pkg::KEY_TIMES: pending_op = kce_pkg::OP_MUL;
                kce_pkg::KEY_SLASH: pending_op = kce_pkg::OP_DIV;
                default:            finish = 1'b1;
            endcase
        end
        if (key_count >= MAX_KEYS) begin
            finish = 1'b1;
        end
        if (!finish) begin
            return 1'b0;
        end
        frac         = acc_mag & ((64'd1 << FRAC_BITS) - 64'd1);
        res.neg      = acc_neg;
        res.int_part = kce_pkg::INT_W'(acc_mag >> FRAC_BITS);
        res.hund     = acc_neg ? '0 : kce_pkg::HUND_W'((frac * 64'd100) >> FRAC_BITS);
        res.status   = first_error;
        clear_calc();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    function automatic logic [kce_pkg::KEY_W-1:0] random_key();
        return kce_pkg::KEY_W'($urandom_range(0, 255));
    endfunction

    // Drop valid for a number of cycles
    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_valid    <= 1'b0;
        i_key_code <= random_key();
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Offer one key word, hold it until taken, and queue its result if any
    task automatic send_key(input logic [kce_pkg::KEY_W-1:0] key);
        t_calc_result res;
        if (burst_left == 0 && !no_gaps) begin
            pause_sender(($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                      : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_key_code <= key;
        do @(posedge i_clk); while (o_stall);
        keys_sent++;
        if (evaluate_key(key, res)) begin
            expected_results.push_back(res);
        end
    endtask

    task automatic send_number(input int value);
        string digits;
        digits = $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++) begin
            send_key(kce_pkg::KEY_W'(digits[i]));
        end
    endtask

    function automatic logic [kce_pkg::KEY_W-1:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return kce_pkg::KEY_PLUS;
            1:       return kce_pkg::KEY_MINUS;
            2:       return kce_pkg::KEY_TIMES;
            default: return kce_pkg::KEY_SLASH;
        endcase
    endfunction

    // A code that is neither digit, operator nor clear
    function automatic logic [kce_pkg::KEY_W-1:0] random_ignored();
        logic [kce_pkg::KEY_W-1:0] key;
        do begin
            key = kce_pkg::KEY_W'($urandom_range(0, 255));
        end while ((key >= kce_pkg::KEY_ZERO && key <= kce_pkg::KEY_NINE) ||
                   key == kce_pkg::KEY_PLUS || key == kce_pkg::KEY_MINUS ||
                   key == kce_pkg::KEY_TIMES || key == kce_pkg::KEY_SLASH ||
                   key == kce_pkg::KEY_EQUAL || key == kce_pkg::KEY_CLEAR);
        return key;
    endfunction

    // Mostly one to five digits; now and then none, giving a zero operand
    task automatic send_random_operand();
        int ndig;
        ndig = ($urandom_range(0, 99) < 6) ? 0 : $urandom_range(1, 5);
        repeat (ndig) send_key(kce_pkg::KEY_ZERO + kce_pkg::KEY_W'($urandom_range(0, 9)));
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall pattern, with an optional long hold-off
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        pattern_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case ((pattern_cycle / 150) % 4)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ((pattern_cycle % 7) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_is_negative) neg_results++;
            if (o_status == kce_pkg::ST_DIV0) div0_results++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result word with none expected: %s%0b %s%0d %s%0d %s%0d",
                             $realtime, "neg=", o_is_negative, "int=", o_integer_part,
                             "hund=", o_hundredths, "st=", o_status);
                end
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_is_negative !== oldest_result.neg ||
                    o_integer_part !== oldest_result.int_part ||
                    o_hundredths !== oldest_result.hund ||
                    o_status !== oldest_result.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: result %0d expected neg=%0b int=%0d hund=%0d st=%0d",
                                 $realtime, results_seen, oldest_result.neg,
                                 oldest_result.int_part, oldest_result.hund,
                                 oldest_result.status);
                        $display("%0t: result %0d actual   neg=%0b int=%0d hund=%0d st=%0d",
                                 $realtime, results_seen, o_is_negative,
                                 o_integer_part, o_hundredths, o_status);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Clear while idle, clear in the middle of an expression
    task automatic test_clear();
        send_key(kce_pkg::KEY_CLEAR);
        send_number(8);
        send_key(kce_pkg::KEY_TIMES);
        send_key(kce_pkg::KEY_CLEAR);
    endtask

    // All four operators, a negative quotient, then a fraction in hundredths
    task automatic test_operators();
        send_number(2);
        send_key(kce_pkg::KEY_PLUS);
        send_number(5);
        send_key(kce_pkg::KEY_TIMES);
        send_number(3);
        send_key(kce_pkg::KEY_MINUS);
        send_number(30);
        send_key(kce_pkg::KEY_SLASH);
        send_number(4);
        send_key(kce_pkg::KEY_EQUAL);
        send_number(1);
        send_key(kce_pkg::KEY_SLASH);
        send_number(3);
        send_key(kce_pkg::KEY_EQUAL);
    endtask

    // Divide by zero saturates, the later overflow keeps the first status;
    // a zero accumulator divided by zero stays zero
    task automatic test_divide_by_zero();
        send_number(9);
        send_key(kce_pkg::KEY_SLASH);
        send_number(0);
        send_key(kce_pkg::KEY_PLUS);
        send_number(1);
        send_key(kce_pkg::KEY_EQUAL);
        send_key(kce_pkg::KEY_SLASH);
        send_number(0);
        send_key(kce_pkg::KEY_EQUAL);
    endtask

    // Operand wrap, ignored codes at both ends, and the key limit with
    // trailing digits dropped
    task automatic test_key_limit();
        send_number(99999);
        send_key(kce_pkg::KEY_PLUS);
        send_key(KEY_LOWEST);
        send_key(KEY_HIGHEST);
        send_number(3);
        send_key(kce_pkg::KEY_TIMES);
        send_number(12);
        send_key(kce_pkg::KEY_MINUS);
        send_number(407);
    endtask

    task automatic test_random_expressions();
        int stop_at;
        int shape;
        int terms;
        stop_at = keys_sent + RANDOM_KEYS;
        while (keys_sent < stop_at) begin
            shape = $urandom_range(0, 99);
            if (shape < 70) begin
                // well-formed expression with random content
                terms = $urandom_range(1, 4);
                for (int t = 0; t < terms; t++) begin
                    send_random_operand();
                    if ($urandom_range(0, 9) == 0) send_key(random_ignored());
                    if (t < terms - 1) send_key(random_operator());
                end
                send_key(kce_pkg::KEY_EQUAL);
            end else if (shape < 80) begin
                // run into the key limit, sometimes with no operator at all
                if ($urandom_range(0, 1) == 0) begin
                    repeat (MAX_KEYS) begin
                        send_key(kce_pkg::KEY_ZERO + kce_pkg::KEY_W'($urandom_range(0, 9)));
                    end
                end else begin
                    repeat (MAX_KEYS) begin
                        case ($urandom_range(0, 5))
                            0:       send_key(random_operator());
                            1:       send_key(random_ignored());
                            default: send_key(kce_pkg::KEY_ZERO +
                                              kce_pkg::KEY_W'($urandom_range(0, 9)));
                        endcase
                    end
                end
            end else if (shape < 90) begin
                // expression cut short by clear
                send_random_operand();
                send_key(random_operator());
                send_random_operand();
                send_key(kce_pkg::KEY_CLEAR);
            end else begin
                // noise over the whole code range
                repeat ($urandom_range(1, 5)) send_key(random_key());
            end
        end
    endtask

    // Hold the output off while short expressions keep coming, so the core
    // fills up and stalls its input
    task automatic test_output_holdoff();
        hold_request = HOLD_CYCLES;
        no_gaps      = 1'b1;
        repeat (6) begin
            send_random_operand();
            send_key(kce_pkg::KEY_TIMES);
            send_random_operand();
            send_key(kce_pkg::KEY_EQUAL);
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_key_code = '0;
        clear_calc();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_clear();
        test_operators();
        test_divide_by_zero();
        test_key_limit();
        test_random_expressions();
        test_output_holdoff();
        test_random_expressions();
        pause_sender(1);

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatches += expected_results.size();

        $display("Sent %0d key words, checked %0d results (%0d negative, %0d divide by zero)",
                 keys_sent, results_seen, neg_results, div0_results);
        $display("Covered every operator, clear, ignored codes, key limit and output hold-off");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/kce_pkg.sv
sv/kce_serial_alu.sv
sv/kce_result_stage.sv
sv/keypad_calculator_evaluator_core.sv
sv/kce_checker.sv
tb/sv/testbench.sv
